// ===== rtl/tkrle_pkg.sv =====
// shared types and constants of the transparent-key run-length encoder
package tkrle_pkg;

  localparam int unsigned OUT_BYTES_DEF = 65536;

  localparam int MAX_RES   = 5;
  localparam int RES_CNT_W = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [7:0] CLEAR_KEY  = 8'hff;
  localparam logic [6:0] OPAQUE_MAX = 7'h7f;
  localparam logic [7:0] CLEAR_MAX  = 8'hff;
  localparam logic [7:0] SKIP_MARK  = 8'h01;
  localparam logic [7:0] ROW_TERM   = 8'h00;

  typedef struct packed {
    logic [15:0] offset;
    logic [7:0]  value;
    logic        ovf;
  } wr_t;

  typedef struct packed {
    wr_t [MAX_RES-1:0]     slot;
    logic [RES_CNT_W-1:0]  cnt;
  } bundle_t;

endpackage

// ===== rtl/transparent_key_rle_encoder.sv =====
// top level: transparent-key run-length encoder for 8-bit sprite pixels
//
// Input channel (in_valid/in_ready) takes one pixel per transfer with its
// row_end and frame_start flags. Output channel (out_valid/out_ready) gives
// one byte write per transfer: offset, value, overflow flag and a flag on
// the last write caused by a pixel. A pixel causes zero to five writes.
// Pixels are registered, encoded combinationally against the run state and
// the writes of one pixel are stored as a group in a four-deep group queue;
// the output register then walks a group one write per cycle while the
// receiver takes writes; a pixel passes the input register, the queue and
// the output register in turn. Throughput: one pixel per cycle while the
// group queue has room; the output side moves one write per cycle unless
// stalled; the long-run pixel rate is set by writes per pixel at the output
// register. A pixel that causes no write still passes the encode stage.
// Reset clears the run state, pointer and the queue; no writes are pending.
// When the receiver stalls the output holds, the queue fills and in_ready
// drops once four groups wait; nothing is lost.
module transparent_key_rle_encoder #(
  parameter int unsigned OUT_BYTES = tkrle_pkg::OUT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_value,
  input  logic        in_row_end,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_byte_offset,
  output logic [7:0]  out_byte_value,
  output logic        out_overflow,
  output logic        out_last_of_step
);
  import tkrle_pkg::*;

  localparam logic [31:0] OUT_LIMIT = 32'(OUT_BYTES);

  // input register
  logic       in_v_r;
  logic [7:0] in_pix_r;
  logic       in_row_end_r;
  logic       in_frame_start_r;

  // run state
  logic [15:0] wp_r, wp_nxt;
  logic        wr_r, wr_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic [6:0]  oc_r, oc_nxt;
  logic [7:0]  cc_r, cc_nxt;

  // group queue
  bundle_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   q_wr_r, q_rd_r;
  logic [QCNT_W-1:0]   q_cnt_r;
  logic [RES_CNT_W-1:0] idx_r;

  // output register
  logic        out_v_r;
  logic [15:0] out_offset_r;
  logic [7:0]  out_value_r;
  logic        out_ovf_r;
  logic        out_last_r;

  bundle_t bnd;
  logic    s_fire, q_full, push, pop, out_load, head_last;
  bundle_t head;

  function automatic logic carry_out(input logic [15:0] base, input logic [2:0] k);
    logic [16:0] s;
    s = {1'b0, base} + {14'b0, k};
    return s[16];
  endfunction

  function automatic wr_t mk(input logic [15:0] off, input logic [7:0] val,
                             input logic wrapped);
    wr_t w;
    w.offset = off;
    w.value  = val;
    w.ovf    = wrapped | ({16'b0, off} >= OUT_LIMIT);
    return w;
  endfunction

  // encode one pixel into its group of writes
  always_comb begin
    logic [15:0] b_wp, b_hs;
    logic        b_wr;
    logic [6:0]  b_oc;
    logic [7:0]  b_cc;
    logic [2:0]  t, n;
    b_wp = in_frame_start_r ? 16'd0 : wp_r;
    b_wr = in_frame_start_r ? 1'b0  : wr_r;
    b_hs = in_frame_start_r ? 16'd0 : hs_r;
    b_oc = in_frame_start_r ? 7'd0  : oc_r;
    b_cc = in_frame_start_r ? 8'd0  : cc_r;
    t = 3'd0;
    n = 3'd0;
    bnd = '0;
    hs_nxt = b_hs;
    oc_nxt = b_oc;
    cc_nxt = b_cc;
    if (in_pix_r != CLEAR_KEY) begin
      // an open transparent run closes first
      if (b_cc != 8'd0) begin
        bnd.slot[n] = mk(b_wp + 16'(t), SKIP_MARK, b_wr | carry_out(b_wp, t + 3'd1));
        n = n + 3'd1;
        t = t + 3'd1;
        bnd.slot[n] = mk(b_wp + 16'(t), b_cc, b_wr | carry_out(b_wp, t + 3'd1));
        n = n + 3'd1;
        t = t + 3'd1;
      end
      cc_nxt = 8'd0;
      // reserve the header slot when the run opens
      if (b_oc == 7'd0) begin
        hs_nxt = b_wp + 16'(t);
        t = t + 3'd1;
      end
      bnd.slot[n] = mk(b_wp + 16'(t), in_pix_r, b_wr | carry_out(b_wp, t + 3'd1));
      n = n + 3'd1;
      t = t + 3'd1;
      oc_nxt = b_oc + 7'd1;
      if (oc_nxt == OPAQUE_MAX || in_row_end_r) begin
        bnd.slot[n] = mk(hs_nxt, {oc_nxt, 1'b1}, b_wr | carry_out(b_wp, t));
        n = n + 3'd1;
        oc_nxt = 7'd0;
      end
    end else begin
      if (b_oc != 7'd0) begin
        bnd.slot[n] = mk(b_hs, {b_oc, 1'b1}, b_wr);
        n = n + 3'd1;
      end
      oc_nxt = 7'd0;
      cc_nxt = b_cc + 8'd1;
      if (cc_nxt == CLEAR_MAX || in_row_end_r) begin
        bnd.slot[n] = mk(b_wp + 16'(t), SKIP_MARK, b_wr | carry_out(b_wp, t + 3'd1));
        n = n + 3'd1;
        t = t + 3'd1;
        bnd.slot[n] = mk(b_wp + 16'(t), cc_nxt, b_wr | carry_out(b_wp, t + 3'd1));
        n = n + 3'd1;
        t = t + 3'd1;
        cc_nxt = 8'd0;
      end
    end
    if (in_row_end_r) begin
      bnd.slot[n] = mk(b_wp + 16'(t), ROW_TERM, b_wr | carry_out(b_wp, t + 3'd1));
      n = n + 3'd1;
      t = t + 3'd1;
    end
    bnd.cnt = n;
    wp_nxt  = b_wp + 16'(t);
    wr_nxt  = b_wr | carry_out(b_wp, t);
  end

  assign q_full    = (q_cnt_r == QCNT_W'(QDEPTH));
  assign s_fire    = in_v_r && !q_full;
  assign in_ready  = !in_v_r || s_fire;
  assign push      = s_fire && (bnd.cnt != '0);
  assign head      = q_mem_r[q_rd_r];
  assign out_load  = !out_v_r || out_ready;
  assign head_last = (idx_r == head.cnt - RES_CNT_W'(1));
  assign pop       = out_load && (q_cnt_r != '0) && head_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      wp_r    <= '0;
      wr_r    <= 1'b0;
      hs_r    <= '0;
      oc_r    <= '0;
      cc_r    <= '0;
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (s_fire) begin
        wp_r <= wp_nxt;
        wr_r <= wr_nxt;
        hs_r <= hs_nxt;
        oc_r <= oc_nxt;
        cc_r <= cc_nxt;
      end
      if (push) begin
        q_wr_r <= q_wr_r + QPTR_W'(1);
      end
      if (pop) begin
        q_rd_r <= q_rd_r + QPTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + QCNT_W'(push) - QCNT_W'(pop);
      if (out_load) begin
        out_v_r <= (q_cnt_r != '0);
        if (q_cnt_r != '0) begin
          idx_r <= head_last ? '0 : idx_r + RES_CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_pix_r         <= in_pixel_value;
      in_row_end_r     <= in_row_end;
      in_frame_start_r <= in_frame_start;
    end
    if (push) begin
      q_mem_r[q_wr_r] <= bnd;
    end
    if (out_load && q_cnt_r != '0) begin
      out_offset_r <= head.slot[idx_r].offset;
      out_value_r  <= head.slot[idx_r].value;
      out_ovf_r    <= head.slot[idx_r].ovf;
      out_last_r   <= head_last;
    end
  end

  assign out_valid        = out_v_r;
  assign out_byte_offset  = out_offset_r;
  assign out_byte_value   = out_value_r;
  assign out_overflow     = out_ovf_r;
  assign out_last_of_step = out_last_r;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("group queue count beyond depth");

  a_no_empty_group: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != '0 |-> (head.cnt != '0 && idx_r < head.cnt))
    else $error("queued group empty or walk index past its end");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r == '0 |-> idx_r == '0)
    else $error("walk index left over with empty queue");

  a_run_limits: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r < OPAQUE_MAX && cc_r < CLEAR_MAX)
    else $error("run counter reached its limit without closing");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(oc_r != '0 && cc_r != '0))
    else $error("opaque and transparent runs open together");

endmodule
